### rtl/core/flm_pkg.sv
// flm_pkg: shared types and constants for the frame loss monitor
// payload structs for the request and response beats, csr register indexes
// no dependencies
package flm_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CsrIndexWidth = 2;

   // csr register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_INTERVAL_MIN = 2'd0,
      CSR_INTERVAL_MAX = 2'd1,
      CSR_WINDOW       = 2'd2
   } csr_index_type;

   // reset values of the csr registers
   localparam logic [DataWidth-1:0] IntervalMinReset = 32'd15000;
   localparam logic [DataWidth-1:0] IntervalMaxReset = 32'd26000;
   localparam logic [DataWidth-1:0] WindowReset      = 32'd1000000;

   // fault flag bit positions
   localparam int unsigned FlagIndexGap = 0;
   localparam int unsigned FlagInterval = 1;

   typedef struct packed {
      logic [DataWidth-1:0] frame_index;
      logic [DataWidth-1:0] time_stamp;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]           fault_flags;
      logic                 window_end;
      logic [DataWidth-1:0] lost_index_total;
      logic [DataWidth-1:0] lost_time_total;
   } rsp_payload_type;

endpackage

### rtl/core/frame_loss_monitor_top.sv
// frame_loss_monitor_top: counts lost frame indexes and timing faults per window
// single module; uses flm_pkg for payload structs and csr indexes
// The response to an accepted beat is registered in the output or skid register.
// Throughput: one beat per cycle while the skid entry is empty; the state update is
// one subtract, add and compare pass, and a two-entry response buffer (output
// register plus skid) keeps req_ready high while one response waits on rsp_ready.
// Reset: synchronous, active high; csr registers return to their defaults, counts
// and history clear, the monitor starts over on the first beat, the buffer empties.
module frame_loss_monitor_top
   import flm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  req_payload_type              req_payload,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rsp_payload_type              rsp_payload,
   // csr write port
   input  logic                         csr_wr_en,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [DataWidth-1:0]         csr_wdata
);

   // csr registers
   logic [DataWidth-1:0] interval_min_ff;
   logic [DataWidth-1:0] interval_max_ff;
   logic [DataWidth-1:0] window_ff;

   // monitor state
   logic                 start_zero_ff, start_zero_in;
   logic [DataWidth-1:0] window_start_ff, window_start_in;
   logic [DataWidth-1:0] prev_index_ff;
   logic [DataWidth-1:0] prev_time_ff;
   logic [DataWidth-1:0] lost_index_ff, lost_index_in;
   logic [DataWidth-1:0] lost_time_ff, lost_time_in;

   // response buffer
   logic                 out_valid_ff, out_valid_in;
   rsp_payload_type      out_data_ff, out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_payload_type      skid_data_ff, skid_data_in;

   // datapath
   logic                 req_beat;
   logic                 rsp_beat;
   logic [DataWidth-1:0] base_index;
   logic [DataWidth-1:0] base_time;
   logic [DataWidth-1:0] base_window;
   logic [DataWidth-1:0] base_lost_index;
   logic [DataWidth-1:0] base_lost_time;
   logic [DataWidth-1:0] index_diff;
   logic                 index_gap;
   logic [DataWidth-1:0] time_diff;
   logic                 interval_fault;
   logic [DataWidth-1:0] lost_index_sum;
   logic [DataWidth-1:0] lost_time_sum;
   logic                 window_close;
   logic                 index_is_zero;
   rsp_payload_type      result;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_min_ff <= IntervalMinReset;
         interval_max_ff <= IntervalMaxReset;
         window_ff       <= WindowReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INTERVAL_MIN: interval_min_ff <= csr_wdata;
            CSR_INTERVAL_MAX: interval_max_ff <= csr_wdata;
            CSR_WINDOW:       window_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // start over takes its baseline from the beat itself
   always_comb begin
      base_index      = start_zero_ff ? req_payload.frame_index : prev_index_ff;
      base_time       = start_zero_ff ? req_payload.time_stamp : prev_time_ff;
      base_window     = start_zero_ff ? req_payload.time_stamp : window_start_ff;
      base_lost_index = start_zero_ff ? '0 : lost_index_ff;
      base_lost_time  = start_zero_ff ? '0 : lost_time_ff;
   end

   // forward index gap of more than one
   assign index_diff = req_payload.frame_index - base_index;
   assign index_gap  = (req_payload.frame_index > base_index) &&
                       (index_diff > DataWidth'(1));

   // absolute interval and range test
   assign time_diff = (req_payload.time_stamp >= base_time) ?
                      (req_payload.time_stamp - base_time) :
                      (base_time - req_payload.time_stamp);
   assign interval_fault = (time_diff != '0) &&
                           ((time_diff < interval_min_ff) ||
                            (time_diff >= interval_max_ff));

   assign lost_index_sum = base_lost_index + (index_gap ? index_diff : '0);
   assign lost_time_sum  = base_lost_time + DataWidth'(interval_fault);

   // window elapsed time, wrapping
   assign window_close  = (req_payload.time_stamp - base_window) >= window_ff;
   assign index_is_zero = (req_payload.frame_index == '0);

   // next state and response
   always_comb begin
      start_zero_in   = (window_close || start_zero_ff) ? index_is_zero : 1'b0;
      window_start_in = window_close ? req_payload.time_stamp : base_window;
      lost_index_in   = window_close ? '0 : lost_index_sum;
      lost_time_in    = window_close ? '0 : lost_time_sum;

      result.fault_flags                = '0;
      result.fault_flags[FlagIndexGap]  = index_gap;
      result.fault_flags[FlagInterval]  = interval_fault;
      result.window_end                 = window_close;
      result.lost_index_total           = window_close ? lost_index_sum : '0;
      result.lost_time_total            = window_close ? lost_time_sum : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_zero_ff   <= 1'b1;
         window_start_ff <= '0;
         prev_index_ff   <= '0;
         prev_time_ff    <= '0;
         lost_index_ff   <= '0;
         lost_time_ff    <= '0;
      end else if (req_beat) begin
         start_zero_ff   <= start_zero_in;
         window_start_ff <= window_start_in;
         prev_index_ff   <= req_payload.frame_index;
         prev_time_ff    <= req_payload.time_stamp;
         lost_index_ff   <= lost_index_in;
         lost_time_ff    <= lost_time_in;
      end
   end

   // response buffer: output register with a skid entry behind it
   assign req_ready   = !skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (rsp_beat) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_beat) begin
         if (!out_valid_ff || rsp_beat) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (rsp_beat) begin
         out_valid_in = 1'b0;
      end else begin
         // nothing moves, buffer holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid entry only fills behind a held output
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a beat into an empty buffer shows up in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && !out_valid_ff) |=> rsp_valid)
      else $error("accepted beat did not reach the response register");

   // totals are zero unless the window closes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.window_end) |->
         (rsp_payload.lost_index_total == '0 && rsp_payload.lost_time_total == '0))
      else $error("window totals reported without window end");

endmodule

### tb/frame_loss_monitor_top_tb.sv
// frame_loss_monitor_top_tb: self-checking bench for the frame loss monitor
// drives frame beats with random gaps, predicts every response and checks it
// depends on flm_pkg and frame_loss_monitor_top
module frame_loss_monitor_top_tb
   import flm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StuckLimit = 1000;
   localparam int unsigned ReportLimit = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_payload_type          req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_payload_type          rsp_payload;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_INTERVAL_MIN;
   logic [DataWidth-1:0]     csr_wdata = '0;

   frame_loss_monitor_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted monitor state and csr copy
   logic        restart_pending = 1'b1;
   logic [31:0] win_start = '0;
   logic [31:0] last_index = '0;
   logic [31:0] last_stamp = '0;
   logic [31:0] gap_total = '0;
   logic [31:0] late_total = '0;
   logic [31:0] cfg_min = IntervalMinReset;
   logic [31:0] cfg_max = IntervalMaxReset;
   logic [31:0] cfg_window = WindowReset;

   req_payload_type pending_frames[$];
   rsp_payload_type expected_results[$];
   rsp_payload_type want;

   // frame stream cursor for the generator
   logic [31:0] cur_index = 32'd1;
   logic [31:0] cur_stamp = '0;

   logic quiet_mode = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_wait = 0;
   int unsigned hold_left = 0;
   int unsigned stuck_cycles = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;
   int unsigned windows_closed = 0;
   int unsigned gap_flags = 0;
   int unsigned timing_flags = 0;
   int unsigned csr_settings = 1;

   // next response of the monitor for one frame beat
   function automatic rsp_payload_type predict_frame(req_payload_type beat);
      logic [31:0] idx;
      logic [31:0] stamp;
      logic [31:0] dt;
      logic [31:0] elapsed;
      rsp_payload_type res;
      idx = beat.frame_index;
      stamp = beat.time_stamp;
      res = '0;
      // start over from this frame
      if (restart_pending) begin
         restart_pending = (idx == 32'd0);
         win_start = stamp;
         last_index = idx;
         last_stamp = stamp;
         gap_total = '0;
         late_total = '0;
      end
      // forward index jump of more than one
      if (idx > last_index && (idx - last_index) > 32'd1) begin
         gap_total = gap_total + (idx - last_index);
         res.fault_flags[FlagIndexGap] = 1'b1;
      end
      last_index = idx;
      // interval check on the absolute difference
      dt = (stamp >= last_stamp) ? stamp - last_stamp : last_stamp - stamp;
      if (dt != 32'd0 && (dt < cfg_min || dt >= cfg_max)) begin
         late_total = late_total + 32'd1;
         res.fault_flags[FlagInterval] = 1'b1;
      end
      last_stamp = stamp;
      // window close
      elapsed = stamp - win_start;
      if (elapsed >= cfg_window) begin
         res.window_end = 1'b1;
         res.lost_index_total = gap_total;
         res.lost_time_total = late_total;
         gap_total = '0;
         late_total = '0;
         restart_pending = (idx == 32'd0);
         win_start = stamp;
      end
      return res;
   endfunction

   // random frame, mostly a well-formed stream with some breakage
   function automatic req_payload_type next_frame();
      req_payload_type beat;
      int unsigned pick;
      logic [31:0] step_ok;
      logic [31:0] step_bad;
      pick = $urandom_range(0, 99);
      if (cfg_max > cfg_min)
         step_ok = $urandom_range(cfg_min, cfg_max - 32'd1);
      else
         step_ok = $urandom_range(1, 40000);
      if ($urandom_range(0, 1) == 0 && cfg_min > 32'd1)
         step_bad = $urandom_range(1, cfg_min - 32'd1);
      else
         step_bad = cfg_max + $urandom_range(0, 50000);
      if (pick < 70) begin
         cur_index = cur_index + 32'd1;
         cur_stamp = cur_stamp + step_ok;
      end else if (pick < 78) begin
         cur_index = cur_index + $urandom_range(2, 40);
         cur_stamp = cur_stamp + step_ok;
      end else if (pick < 84) begin
         cur_index = cur_index + 32'd1;
         cur_stamp = cur_stamp + step_bad;
      end else if (pick < 88) begin
         cur_index = cur_index - $urandom_range(0, 3);
         cur_stamp = cur_stamp + step_ok;
      end else if (pick < 91) begin
         cur_index = '0;
         cur_stamp = cur_stamp + step_ok;
      end else if (pick < 94) begin
         cur_index = cur_index + 32'd1;
      end else if (pick < 97) begin
         cur_index = cur_index + 32'd1;
         cur_stamp = cur_stamp - $urandom_range(1, 30000);
      end else begin
         cur_index = $urandom;
         cur_stamp = $urandom;
      end
      beat.frame_index = cur_index;
      beat.time_stamp = cur_stamp;
      return beat;
   endfunction

   task automatic queue_frame(input logic [31:0] idx, input logic [31:0] stamp);
      req_payload_type beat;
      beat.frame_index = idx;
      beat.time_stamp = stamp;
      pending_frames.push_back(beat);
   endtask

   task automatic queue_random(input int unsigned count);
      for (int unsigned n = 0; n < count; n++)
         pending_frames.push_back(next_frame());
   endtask

   task automatic write_csr(input csr_index_type which, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      case (which)
         CSR_INTERVAL_MIN: cfg_min = value;
         CSR_INTERVAL_MAX: cfg_max = value;
         CSR_WINDOW:       cfg_window = value;
         default:          ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] win);
      write_csr(CSR_INTERVAL_MIN, lo);
      write_csr(CSR_INTERVAL_MAX, hi);
      write_csr(CSR_WINDOW, win);
      csr_settings++;
      @(negedge clock);
   endtask

   // wait for every queued beat to be answered, then let the pipe settle
   task automatic settle();
      do
         @(negedge clock);
      while (pending_frames.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] exp_value,
                                  input logic [31:0] got_value);
      mismatches++;
      if (mismatches <= ReportLimit)
         $display("response %0d: %s expected %h got %h", results_seen, field,
                  exp_value, got_value);
   endtask

   // frame beat driver, predicts each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(predict_frame(req_payload));
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
               req_payload <= pending_frames.pop_front();
               req_valid <= 1'b1;
               send_gap = quiet_mode ? 0 : $urandom_range(0, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random and long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat, lost_index_total", '0,
                               rsp_payload.lost_index_total);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.fault_flags !== want.fault_flags)
                  report_mismatch("fault_flags", want.fault_flags, rsp_payload.fault_flags);
               if (rsp_payload.window_end !== want.window_end)
                  report_mismatch("window_end", want.window_end, rsp_payload.window_end);
               if (rsp_payload.lost_index_total !== want.lost_index_total)
                  report_mismatch("lost_index_total", want.lost_index_total,
                                  rsp_payload.lost_index_total);
               if (rsp_payload.lost_time_total !== want.lost_time_total)
                  report_mismatch("lost_time_total", want.lost_time_total,
                                  rsp_payload.lost_time_total);
               windows_closed += want.window_end;
               gap_flags += want.fault_flags[FlagIndexGap];
               timing_flags += want.fault_flags[FlagInterval];
            end
            results_seen++;
            recv_wait = quiet_mode ? 0 : $urandom_range(0, 7);
            // now and then back off long enough to fill the response buffer
            if (results_seen % 500 == 250)
               hold_left = 120;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_wait != 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with work outstanding but no beat moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_frames.size() == 0 && !req_valid && expected_results.size() == 0)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= StuckLimit) begin
            $display("watchdog: no beat moved for %0d cycles", stuck_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] win;
      logic [31:0] base;
      logic [31:0] open_at;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames at the reset settings
      queue_frame(32'd0, 32'd0);                // index zero keeps restarting
      queue_frame(32'd0, 32'd100);
      queue_frame(32'd5, 32'd20100);            // restart at nonzero index
      queue_frame(32'd6, 32'd40100);
      queue_frame(32'd9, 32'd60100);            // index gap
      queue_frame(32'd9, 32'd80100);            // repeated index
      queue_frame(32'd4, 32'd100100);           // backward index
      queue_frame(32'd5, 32'd100100);           // zero interval
      queue_frame(32'd6, 32'd100000);           // time running backward
      queue_frame(32'd7, 32'd130000);           // interval too long
      queue_frame(32'd8, 32'd144999);           // just under minimum
      queue_frame(32'd9, 32'd159999);           // exactly minimum
      queue_frame(32'd10, 32'd185999);          // exactly maximum
      queue_frame(32'd11, 32'd211998);
      queue_frame(32'hFFFF_FFFF, 32'd232000);   // largest index jump
      queue_frame(32'd0, 32'd1100000);          // window close on index zero
      queue_frame(32'hFFFF_FFFE, 32'hFFFF_FFF0);
      queue_frame(32'hFFFF_FFFF, 32'h0000_4000); // timestamp wrap
      queue_frame(32'd1, 32'hFFFF_FFFF);
      queue_frame(32'd2, 32'hFFFF_FFFF);
      settle();

      // widest interval band, window length of one
      set_config(32'd0, 32'hFFFF_FFFF, 32'd1);
      cur_stamp = $urandom;
      queue_random(150);
      settle();

      // minimum above maximum, longest window, counts wrapping
      set_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      base = $urandom;
      open_at = restart_pending ? base : win_start;
      queue_frame(32'd1, base);
      queue_frame(32'h8000_0001, base + 32'd1);
      queue_frame(32'hFFFF_FFFF, base + 32'd2);
      queue_frame(32'd1, base + 32'd3);
      queue_frame(32'h8000_0001, base + 32'd4);
      queue_frame(32'd2, open_at - 32'd1);     // elapsed reaches the full range
      cur_index = 32'd2;
      cur_stamp = open_at - 32'd1;
      queue_random(150);
      settle();

      set_config(32'd30000, 32'd10000, 32'd200000);
      queue_random(150);

      // typical settings, two of them with no random idling
      for (int p = 0; p < 6; p++) begin
         settle();
         lo = $urandom_range(1000, 20000);
         hi = lo + $urandom_range(1, 20000);
         win = $urandom_range(2 * hi, 60 * hi);
         set_config(lo, hi, win);
         quiet_mode = (p == 1 || p == 4);
         queue_random(200);
      end
      settle();
      repeat (4) @(posedge clock);

      $display("covered %0d frame beats over %0d csr settings, %0d windows closed",
               results_seen, csr_settings, windows_closed);
      $display("%0d index gaps and %0d interval faults flagged, %0d mismatches",
               gap_flags, timing_flags, mismatches);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
